/* hw/rtl/utf8vpt_pkg.sv */
// Shared types, constants and helpers for the UTF-8 valid-prefix truncator.
// No dependencies; utf8vpt_core, utf8vpt_out_reg and the top level refer to this package by scope.
`timescale 1ns / 1ps

package utf8vpt_pkg;

  localparam int unsigned CountWidth = 32;   // message byte counter, 16..64
  localparam int unsigned LenWidth   = 16;
  localparam int unsigned OmitWidth  = 32;

  localparam logic [LenWidth-1:0]   MaxLenReset = 16'd200;
  localparam logic [CountWidth-1:0] CountMax    = {CountWidth{1'b1}};
  localparam logic [63:0]           OmitMax     = 64'h0000_0000_FFFF_FFFF;

  // UTF-8 structural patterns, matched on the top bits of a byte
  localparam logic [1:0] ContPat    = 2'b10;
  localparam logic [2:0] LeadTwoPat = 3'b110;
  localparam logic [3:0] LeadThrPat = 4'b1110;
  localparam logic [4:0] LeadFouPat = 5'b11110;

  typedef struct packed {
    logic [OmitWidth-1:0] omitted_bytes;
    logic                 truncated;
    logic [LenWidth-1:0]  valid_length;
  } result_t;

  function automatic logic [OmitWidth-1:0] sat_omit(input logic [CountWidth-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > OmitMax) begin
      return OmitMax[OmitWidth-1:0];
    end
    return w[OmitWidth-1:0];
  endfunction

endpackage

/* hw/rtl/utf8vpt_core.sv */
// Per-message UTF-8 structure checker: holds the message state and the
// max_length register, and forms the result on the final beat. Uses utf8vpt_pkg.
`timescale 1ns / 1ps

module utf8vpt_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [utf8vpt_pkg::LenWidth-1:0]   cfg_data_i,
  input  logic                               beat_valid_i,
  input  logic [7:0]                         beat_byte_i,
  input  logic                               beat_last_i,
  output logic                               res_valid_o,
  output utf8vpt_pkg::result_t               res_o
);

  logic [utf8vpt_pkg::LenWidth-1:0]   max_len_q;
  logic [1:0]                         pend_q, pend_d;
  logic [utf8vpt_pkg::CountWidth-1:0] pos_q, pos_d;
  logic [utf8vpt_pkg::LenWidth-1:0]   bound_q, bound_d;
  logic                               stop_q, stop_d;
  logic [utf8vpt_pkg::CountWidth-1:0] max_ext;
  logic [utf8vpt_pkg::LenWidth-1:0]   next_bound;
  logic                               in_window;

  assign max_ext    = utf8vpt_pkg::CountWidth'(max_len_q);
  assign next_bound = pos_q[utf8vpt_pkg::LenWidth-1:0] + 16'd1;
  assign in_window  = !stop_q && (pos_q < max_ext);

  always_comb begin
    pend_d      = pend_q;
    pos_d       = pos_q;
    bound_d     = bound_q;
    stop_d      = stop_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (beat_valid_i) begin
      if (in_window) begin
        if (pend_q == 2'd0) begin
          if (!beat_byte_i[7]) begin
            bound_d = next_bound;
          end else if (beat_byte_i[7:5] == utf8vpt_pkg::LeadTwoPat) begin
            pend_d = 2'd1;
          end else if (beat_byte_i[7:4] == utf8vpt_pkg::LeadThrPat) begin
            pend_d = 2'd2;
          end else if (beat_byte_i[7:3] == utf8vpt_pkg::LeadFouPat) begin
            pend_d = 2'd3;
          end else begin
            stop_d = 1'b1;
          end
        end else if (beat_byte_i[7:6] != utf8vpt_pkg::ContPat) begin
          // boundary still sits before the broken sequence's lead
          stop_d = 1'b1;
        end else begin
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            bound_d = next_bound;
          end
        end
      end
      if (pos_q != utf8vpt_pkg::CountMax) begin
        pos_d = pos_q + utf8vpt_pkg::CountWidth'(1);
      end
      if (beat_last_i) begin
        res_valid_o        = 1'b1;
        res_o.valid_length = bound_d;
        res_o.truncated    = pos_d > max_ext;
        res_o.omitted_bytes = (pos_d > max_ext) ? utf8vpt_pkg::sat_omit(pos_d - max_ext) : '0;
        // clear for the next message
        pend_d  = 2'd0;
        pos_d   = '0;
        bound_d = '0;
        stop_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= utf8vpt_pkg::MaxLenReset;
      pend_q    <= 2'd0;
      pos_q     <= '0;
      bound_q   <= '0;
      stop_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      bound_q <= bound_d;
      stop_q  <= stop_d;
    end
  end

endmodule

/* hw/rtl/utf8vpt_out_reg.sv */
// Result register on the master side: holds one result beat until taken.
// Uses utf8vpt_pkg::result_t.
`timescale 1ns / 1ps

module utf8vpt_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  utf8vpt_pkg::result_t res_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output utf8vpt_pkg::result_t res_o,
  output logic                 free_o
);

  logic                 valid_q, valid_d;
  utf8vpt_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* hw/rtl/utf8_valid_prefix_truncator.sv */
// Top level of the UTF-8 valid-prefix truncator: input register, checker core
// and result register. Depends on utf8vpt_pkg, utf8vpt_core, utf8vpt_out_reg.
`timescale 1ns / 1ps

// Feed a message one byte per beat with tlast on its final byte. The first
// max_length bytes (cfg port, reset 200) are checked for UTF-8 structure only;
// on the final byte one result beat carries the length of the complete,
// well-formed prefix, a truncated flag and the saturating count of bytes past
// max_length. A byte is taken every cycle while no final byte stalls: each
// beat passes the input register, then the core's combinational state update
// loads the result register. Non-final bytes keep flowing while a result
// waits; only a final byte stalls behind an untaken result. Write max_length
// only while no message is in flight.
module utf8_valid_prefix_truncator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [utf8vpt_pkg::LenWidth-1:0]   cfg_data_i,     // max_length
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
  input  logic                               s_axis_tlast,   // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [47:0]                        m_axis_tdata,   // [15:0] valid_length,
                                                             // [47:16] omitted_bytes
  output logic [0:0]                         m_axis_tuser    // [0] truncated
);

  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic                 advance;
  logic                 out_free;
  logic                 res_valid;
  utf8vpt_pkg::result_t res, out_res;

  assign cfg_ready_o   = 1'b1;
  // a final byte waits until the result register can take its result
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) ? 1'b1 : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  utf8vpt_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .beat_valid_i (advance),
    .beat_byte_i  (in_byte_q),
    .beat_last_i  (in_last_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  utf8vpt_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res),
    .free_o  (out_free)
  );

  assign m_axis_tdata = {out_res.omitted_bytes, out_res.valid_length};
  assign m_axis_tuser = out_res.truncated;

endmodule

/* hw/rtl/utf8vpt_checker.sv */
// Port-level checks for utf8_valid_prefix_truncator, bound to the top level.
// Depends on utf8_valid_prefix_truncator only.
`timescale 1ns / 1ps

module utf8vpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // hold a stalled result beat
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_no_trunc_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[47:16] == 32'd0)
    else $error("omitted count set on an untruncated message");

  a_trunc_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:16] != 32'd0)
    else $error("truncated message with no omitted bytes");

  // input side stalls only behind an untaken result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind utf8_valid_prefix_truncator utf8vpt_checker u_checker (.*);
